// ===== hw/rtl/arp_cache_resolver_assert.svh =====
// assertion macros for the address-resolution cache engine
`ifndef ARP_CACHE_RESOLVER_ASSERT_SVH
`define ARP_CACHE_RESOLVER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define ARPCR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arp cache resolver: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define ARPCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arp cache resolver: next-cycle check failed");

`else

`define ARPCR_ASSERT_NOW(label, ante, cons)
`define ARPCR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/arpcr_pkg.sv =====
// shared types and constants for the address-resolution cache engine
`default_nettype none

package arpcr_pkg;

    localparam int MIP_W      = 8;
    localparam int MAC_W      = 48;
    localparam int IF_W       = 3;
    localparam int LEN_W      = 11;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [LEN_W-1:0] MIN_PAYLOAD = 11'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_CODE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] LOCAL_ADDRESS_RST = 8'd0;
    localparam logic [CFG_DATA_W-1:0] REQUEST_CODE_RST  = 8'd0;
    localparam logic [CFG_DATA_W-1:0] RESPONSE_CODE_RST = 8'd1;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_IGNORED       = 3'd0,
        STATUS_SEND_RESPONSE = 3'd1,
        STATUS_RESOLVED      = 3'd2,
        STATUS_TOO_SHORT     = 3'd3,
        STATUS_UNKNOWN_KIND  = 3'd4,
        STATUS_HIT           = 3'd5,
        STATUS_MISS          = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_LEARN  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_WRITE  = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic search;
        logic write;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    search_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/arpcr_datapath.sv =====
// datapath: config registers, item latch, cache table, search and result registers
`default_nettype none

module arpcr_datapath #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire arpcr_pkg::dp_cmd_t                  cmd,
    output arpcr_pkg::dp_stat_t                      stat,
    input  wire logic                                cfg_we,
    input  wire logic [arpcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [arpcr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                opcode,
    input  wire logic [7:0]                          arp_kind,
    input  wire logic [arpcr_pkg::MIP_W-1:0]         asked_mip,
    input  wire logic [arpcr_pkg::LEN_W-1:0]         payload_len,
    input  wire logic [arpcr_pkg::MIP_W-1:0]         sender_mip,
    input  wire logic [arpcr_pkg::MAC_W-1:0]         sender_mac,
    input  wire logic [arpcr_pkg::IF_W-1:0]          rx_interface,
    input  wire logic [arpcr_pkg::MIP_W-1:0]         lookup_mip,
    output logic                                     done,
    output logic [arpcr_pkg::STATUS_W-1:0]           status,
    output logic [arpcr_pkg::MIP_W-1:0]              out_mip,
    output logic [arpcr_pkg::MAC_W-1:0]              out_mac,
    output logic [arpcr_pkg::IF_W-1:0]               out_interface
);

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CACHE_ENTRIES);

    // configuration
    logic [7:0] local_address_reg;
    logic [7:0] request_code_reg;
    logic [7:0] response_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= arpcr_pkg::LOCAL_ADDRESS_RST;
            request_code_reg  <= arpcr_pkg::REQUEST_CODE_RST;
            response_code_reg <= arpcr_pkg::RESPONSE_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                arpcr_pkg::CFG_LOCAL_ADDRESS: local_address_reg <= cfg_data;
                arpcr_pkg::CFG_REQUEST_CODE:  request_code_reg  <= cfg_data;
                arpcr_pkg::CFG_RESPONSE_CODE: response_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // classify the incoming word
    arpcr_pkg::action_t action_next;
    arpcr_pkg::status_t base_status_next;
    logic [arpcr_pkg::MIP_W-1:0] key_next;

    always_comb
    begin
        action_next      = arpcr_pkg::ACT_NONE;
        base_status_next = arpcr_pkg::STATUS_IGNORED;
        key_next         = sender_mip;
        if (opcode == arpcr_pkg::OP_LOOKUP)
        begin
            action_next = arpcr_pkg::ACT_LOOKUP;
            key_next    = lookup_mip;
        end
        else if (payload_len < arpcr_pkg::MIN_PAYLOAD)
        begin
            base_status_next = arpcr_pkg::STATUS_TOO_SHORT;
        end
        else if (arp_kind == request_code_reg)
        begin
            if (asked_mip == local_address_reg)
            begin
                action_next      = arpcr_pkg::ACT_LEARN;
                base_status_next = arpcr_pkg::STATUS_SEND_RESPONSE;
            end
        end
        else if (arp_kind == response_code_reg)
        begin
            // asked address equals sender here, so the sender key serves
            if (asked_mip == sender_mip)
            begin
                action_next      = arpcr_pkg::ACT_LEARN;
                base_status_next = arpcr_pkg::STATUS_RESOLVED;
            end
        end
        else
        begin
            base_status_next = arpcr_pkg::STATUS_UNKNOWN_KIND;
        end
    end

    arpcr_pkg::action_t          action_reg;
    arpcr_pkg::status_t          base_status_reg;
    logic [arpcr_pkg::MIP_W-1:0] key_reg;
    logic [arpcr_pkg::MAC_W-1:0] mac_reg;
    logic [arpcr_pkg::IF_W-1:0]  if_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= arpcr_pkg::ACT_NONE;
        end
        else if (cmd.load)
        begin
            action_reg <= action_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_status_reg <= base_status_next;
            key_reg         <= key_next;
            mac_reg         <= sender_mac;
            if_reg          <= rx_interface;
        end
    end

    // cache table, single port, registered read
    logic [arpcr_pkg::MIP_W-1:0] mem_addr [CACHE_ENTRIES];
    logic [arpcr_pkg::MAC_W-1:0] mem_mac  [CACHE_ENTRIES];
    logic [arpcr_pkg::IF_W-1:0]  mem_if   [CACHE_ENTRIES];

    logic [arpcr_pkg::MIP_W-1:0] rd_addr_reg;
    logic [arpcr_pkg::MAC_W-1:0] rd_mac_reg;
    logic [arpcr_pkg::IF_W-1:0]  rd_if_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] rd_idx_reg;
    logic [IW-1:0] pend_idx_reg;
    logic          pend_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [arpcr_pkg::MAC_W-1:0] hit_mac_reg;
    logic [arpcr_pkg::IF_W-1:0]  hit_if_reg;

    logic          hit_now;
    logic          rd_en;
    logic          wr_en;
    logic          room;
    logic [IW-1:0] wr_idx;

    assign hit_now = pend_reg && !hit_reg && (rd_addr_reg == key_reg);
    assign rd_en   = cmd.search && (rd_idx_reg < count_reg) && !hit_reg && !hit_now;
    assign room    = count_reg < FULL_COUNT;
    assign wr_en   = cmd.write && (hit_reg || room);
    assign wr_idx  = hit_reg ? hit_idx_reg : count_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_addr[wr_idx] <= key_reg;
            mem_mac[wr_idx]  <= mac_reg;
            mem_if[wr_idx]   <= if_reg;
        end
        if (rd_en)
        begin
            rd_addr_reg <= mem_addr[rd_idx_reg[IW-1:0]];
            rd_mac_reg  <= mem_mac[rd_idx_reg[IW-1:0]];
            rd_if_reg   <= mem_if[rd_idx_reg[IW-1:0]];
        end
    end

    // walk control: one read issued per cycle, compared the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
                hit_reg    <= 1'b0;
            end
            else
            begin
                pend_reg <= rd_en;
                if (rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                end
                if (hit_now)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.write && !hit_reg && room)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pend_idx_reg <= rd_idx_reg[IW-1:0];
        end
        if (hit_now)
        begin
            hit_idx_reg <= pend_idx_reg;
            hit_mac_reg <= rd_mac_reg;
            hit_if_reg  <= rd_if_reg;
        end
    end

    assign stat.action      = action_reg;
    assign stat.search_done = (action_reg == arpcr_pkg::ACT_NONE) || hit_reg
                              || (!pend_reg && (rd_idx_reg >= count_reg));

    // result registers
    arpcr_pkg::status_t          status_next;
    logic [arpcr_pkg::MIP_W-1:0] out_mip_next;
    logic [arpcr_pkg::MAC_W-1:0] out_mac_next;
    logic [arpcr_pkg::IF_W-1:0]  out_if_next;

    always_comb
    begin
        status_next  = base_status_reg;
        out_mip_next = '0;
        out_mac_next = '0;
        out_if_next  = '0;
        case (action_reg)
            arpcr_pkg::ACT_LOOKUP:
            begin
                if (hit_reg)
                begin
                    status_next  = arpcr_pkg::STATUS_HIT;
                    out_mip_next = key_reg;
                    out_mac_next = hit_mac_reg;
                    out_if_next  = hit_if_reg;
                end
                else
                begin
                    status_next = arpcr_pkg::STATUS_MISS;
                end
            end
            arpcr_pkg::ACT_LEARN:
            begin
                out_mip_next = key_reg;
                out_mac_next = mac_reg;
                out_if_next  = if_reg;
            end
            default: ;
        endcase
    end

    logic                             done_reg;
    logic [arpcr_pkg::STATUS_W-1:0]   status_reg;
    logic [arpcr_pkg::MIP_W-1:0]      out_mip_reg;
    logic [arpcr_pkg::MAC_W-1:0]      out_mac_reg;
    logic [arpcr_pkg::IF_W-1:0]       out_if_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg  <= status_next;
            out_mip_reg <= out_mip_next;
            out_mac_reg <= out_mac_next;
            out_if_reg  <= out_if_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign out_mip       = out_mip_reg;
    assign out_mac       = out_mac_reg;
    assign out_interface = out_if_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/arpcr_ctrl.sv =====
// controller: sequences load, table walk, write-back and result strobe
`default_nettype none

module arpcr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire arpcr_pkg::dp_stat_t  stat,
    output arpcr_pkg::dp_cmd_t        cmd
);

    arpcr_pkg::state_t state_reg;
    arpcr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arpcr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            arpcr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = arpcr_pkg::ST_SEARCH;
                end
            end
            arpcr_pkg::ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (stat.search_done)
                begin
                    if (stat.action == arpcr_pkg::ACT_LEARN)
                    begin
                        state_next = arpcr_pkg::ST_WRITE;
                    end
                    else
                    begin
                        cmd.emit   = 1'b1;
                        state_next = arpcr_pkg::ST_IDLE;
                    end
                end
            end
            arpcr_pkg::ST_WRITE:
            begin
                cmd.write  = 1'b1;
                cmd.emit   = 1'b1;
                state_next = arpcr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = arpcr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != arpcr_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/arp_cache_resolver.sv =====
// words that need no table walk are loaded, pass the search state and get a registered done
// table walk: one entry read per cycle from the single-port cache table, stopping at a
// hit or after the last stored entry; a learn then passes the write-back state
// a new start is taken in the cycle done is high; the receiver cannot stall results
// reset clears the entry count and sets the config registers to their reset values, table contents stay unwritten
`default_nettype none
`include "arp_cache_resolver_assert.svh"

module arp_cache_resolver #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                cfg_we,
    input  wire logic [arpcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [arpcr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                opcode,
    input  wire logic [7:0]                          arp_kind,
    input  wire logic [arpcr_pkg::MIP_W-1:0]         asked_mip,
    input  wire logic [arpcr_pkg::LEN_W-1:0]         payload_len,
    input  wire logic [arpcr_pkg::MIP_W-1:0]         sender_mip,
    input  wire logic [arpcr_pkg::MAC_W-1:0]         sender_mac,
    input  wire logic [arpcr_pkg::IF_W-1:0]          rx_interface,
    input  wire logic [arpcr_pkg::MIP_W-1:0]         lookup_mip,
    output logic                                     done,
    output logic [arpcr_pkg::STATUS_W-1:0]           status,
    output logic [arpcr_pkg::MIP_W-1:0]              out_mip,
    output logic [arpcr_pkg::MAC_W-1:0]              out_mac,
    output logic [arpcr_pkg::IF_W-1:0]               out_interface
);

    arpcr_pkg::dp_cmd_t  cmd;
    arpcr_pkg::dp_stat_t stat;

    arpcr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    arpcr_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .arp_kind      (arp_kind),
        .asked_mip     (asked_mip),
        .payload_len   (payload_len),
        .sender_mip    (sender_mip),
        .sender_mac    (sender_mac),
        .rx_interface  (rx_interface),
        .lookup_mip    (lookup_mip),
        .done          (done),
        .status        (status),
        .out_mip       (out_mip),
        .out_mac       (out_mac),
        .out_interface (out_interface)
    );

    // result word only appears once the controller is back in idle
    `ARPCR_ASSERT_NOW(a_done_idle, done, !busy)
    // an accepted word always occupies the engine the cycle after
    `ARPCR_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // exactly one strobe per word, never two in a row
    `ARPCR_ASSERT_NEXT(a_done_single, done, !done)
    // write-back always ends in a result strobe
    `ARPCR_ASSERT_NEXT(a_write_emits, cmd.write, done)

endmodule

`default_nettype wire
